// ===== hw/rtl/ascii_integer_scanner_core_macros.svh =====
`ifndef ASCII_INTEGER_SCANNER_CORE_MACROS_SVH
`define ASCII_INTEGER_SCANNER_CORE_MACROS_SVH

// Clocked check, switched off while reset is held.
`define AIS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scanner port check failed");

// Clocked check that also covers the reset cycles.
`define AIS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("scanner reset check failed");

`endif

// ===== hw/rtl/ais_pkg.sv =====
`default_nettype none

package ais_pkg;

    // characters the scanner reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DECIMAL_MODE     = 2'd0;
    localparam t_cfg_idx CFG_SKIP_LEADING     = 2'd1;
    localparam t_cfg_idx CFG_SIGNED_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic decimal_mode;
        logic skip_leading;
        logic signed_not_found;
    } t_cfg;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_item;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // digit value of c; hex letters only when hex is set
    function automatic t_digit digit_of(logic [7:0] c, logic hex);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d.ok  = 1'b1;
            d.val = c[3:0];
        end else if (hex && ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))) begin
            // 'a'/'A' have low nibble 1
            d.ok  = 1'b1;
            d.val = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ais_in_stage.sv =====
`default_nettype none

module ais_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ais_pkg::t_item i_item,
    output logic               o_valid,
    output ais_pkg::t_item     o_item,
    input  wire logic          i_take
);

    logic           r_valid;
    ais_pkg::t_item r_item;

    // slot frees in the same cycle the scan stage takes the held item
    assign o_ready = i_rst_n && (!r_valid || i_take);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
            r_item  <= i_item;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ais_scan.sv =====
`default_nettype none

module ais_scan #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_MAX  = 255
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ais_pkg::t_cfg   i_cfg,
    input  wire logic            i_valid,
    input  wire ais_pkg::t_item  i_item,
    output logic                 o_take,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                 o_found,
    output logic [7:0]           o_consumed
);

    localparam int CNT_RAW = $clog2(COUNT_MAX + 1);
    localparam int CNT_W   = (CNT_RAW > 8) ? CNT_RAW : 8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SKIP,
        PH_SCAN
    } t_phase;

    t_phase                r_phase, b_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, b_acc, n_acc;
    logic                  r_neg, b_neg, n_neg;
    logic                  r_found, b_found, n_found;
    logic                  r_hex, b_hex, n_hex;
    logic [CNT_W-1:0]      r_cnt, b_cnt, n_cnt;
    logic                  n_emit;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_res_found;
    logic [7:0]            r_consumed;

    ais_pkg::t_digit       dig;
    logic                  is_nul, is_minus, is_x;
    logic [CNT_W-1:0]      cnt_inc;
    logic [VALUE_BITS-1:0] prod, acc_step, res_val;

    assign o_take     = i_valid && (!r_out_valid || i_ready);
    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_found    = r_res_found;
    assign o_consumed = r_consumed;

    always_comb begin
        b_phase = r_phase;
        b_acc   = r_acc;
        b_neg   = r_neg;
        b_found = r_found;
        b_hex   = r_hex;
        b_cnt   = r_cnt;
        // a start drops whatever scan was open
        if (i_item.start_req) begin
            b_phase = i_cfg.skip_leading ? PH_SKIP : PH_SCAN;
            b_acc   = '0;
            b_neg   = 1'b0;
            b_found = 1'b0;
            b_hex   = !i_cfg.decimal_mode;
            b_cnt   = '0;
        end

        dig      = ais_pkg::digit_of(i_item.ch, b_hex);
        is_nul   = (i_item.ch == ais_pkg::CH_NUL);
        is_minus = (i_item.ch == ais_pkg::CH_MINUS);
        is_x     = (i_item.ch == ais_pkg::CH_LX) || (i_item.ch == ais_pkg::CH_UX);
        cnt_inc  = (b_cnt < CNT_W'(COUNT_MAX)) ? b_cnt + CNT_W'(1) : b_cnt;
        // x10 as shift-add, x16 as shift
        prod     = b_hex ? (b_acc << 4) : ((b_acc << 3) + (b_acc << 1));
        acc_step = prod + VALUE_BITS'(dig.val);

        if (b_found) begin
            res_val = b_neg ? ('0 - b_acc) : b_acc;
        end else if (i_cfg.signed_not_found) begin
            res_val = {1'b1, {(VALUE_BITS-1){1'b0}}};
        end else begin
            res_val = '1;
        end

        n_phase = b_phase;
        n_acc   = b_acc;
        n_neg   = b_neg;
        n_found = b_found;
        n_hex   = b_hex;
        n_cnt   = b_cnt;
        n_emit  = 1'b0;

        unique case (b_phase)
            PH_SKIP, PH_SCAN: begin
                if (b_phase == PH_SKIP && !is_nul && !dig.ok && !is_minus) begin
                    n_cnt = cnt_inc;
                end else if (is_nul) begin
                    n_emit  = 1'b1;
                end else if (dig.ok) begin
                    n_acc   = acc_step;
                    n_found = 1'b1;
                    n_cnt   = cnt_inc;
                    n_phase = PH_SCAN;
                end else if (b_acc != '0) begin
                    n_emit  = 1'b1;
                end else if (is_x) begin
                    // value is zero here, so the product stays zero
                    n_hex   = 1'b1;
                    n_acc   = acc_step;
                    n_found = 1'b1;
                    n_cnt   = cnt_inc;
                    n_phase = PH_SCAN;
                end else if (is_minus) begin
                    n_neg   = 1'b1;
                    n_acc   = acc_step;
                    n_found = 1'b1;
                    n_cnt   = cnt_inc;
                    n_phase = PH_SCAN;
                end else begin
                    n_emit  = 1'b1;
                end
                if (n_emit) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_found     <= 1'b0;
            r_hex       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_found <= n_found;
                r_hex   <= n_hex;
                r_cnt   <= n_cnt;
            end
            if (o_take && n_emit) begin
                r_out_valid <= 1'b1;
                r_value     <= res_val;
                r_res_found <= b_found;
                r_consumed  <= b_cnt[7:0];
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_integer_scanner_core.sv =====
`default_nettype none

// Integer scanner: takes one character per item on s_axis and, when a scan
// ends, emits one item on m_axis holding the value, the found flag and the
// count of consumed characters. An input register feeds a single scan stage
// (one shift-add per character) whose result lands in an output register, and
// one character can be accepted each cycle unless m_axis stalls while both
// registers hold an item. When both registers hold an item, s_axis_tready
// follows m_axis_tready. Base and skip choice are sampled on the start item;
// the not-found code is chosen when the result is produced. Configuration
// writes are taken at once.
module ascii_integer_scanner_core #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_MAX  = 255
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] ch
    input  wire logic   s_axis_tuser,       // [0] start_req
    output logic        m_axis_tvalid,
    input  wire logic   m_axis_tready,
    output logic [((VALUE_BITS + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata, // value, consumed, zero pad
    output logic        m_axis_tuser,       // [0] found
    input  wire logic   i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire ais_pkg::t_cfg_idx i_cfg_index,
    input  wire logic   i_cfg_data
);

    localparam int OUT_W = ((VALUE_BITS + 8 + 7) / 8) * 8;

    ais_pkg::t_cfg         r_cfg;
    ais_pkg::t_item        in_item, st_item;
    logic                  st_valid, st_take;
    logic [VALUE_BITS-1:0] res_value;
    logic [7:0]            res_consumed;

    assign o_cfg_ready       = i_rst_n;
    assign in_item.ch        = s_axis_tdata;
    assign in_item.start_req = s_axis_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decimal_mode     <= 1'b1;
            r_cfg.skip_leading     <= 1'b1;
            r_cfg.signed_not_found <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ais_pkg::CFG_DECIMAL_MODE:     r_cfg.decimal_mode     <= i_cfg_data;
                ais_pkg::CFG_SKIP_LEADING:     r_cfg.skip_leading     <= i_cfg_data;
                ais_pkg::CFG_SIGNED_NOT_FOUND: r_cfg.signed_not_found <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ais_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (st_take)
    );

    ais_scan #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_MAX  (COUNT_MAX)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (st_valid),
        .i_item     (st_item),
        .o_take     (st_take),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (res_value),
        .o_found    (m_axis_tuser),
        .o_consumed (res_consumed)
    );

    assign m_axis_tdata = OUT_W'({res_consumed, res_value});

endmodule

`default_nettype wire

// ===== hw/rtl/ais_checker.sv =====
`default_nettype none

`include "ascii_integer_scanner_core_macros.svh"

module ais_checker #(
    parameter int VALUE_BITS = 32,
    parameter int OUT_W      = 40
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic             m_axis_tuser
);

    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [VALUE_BITS-1:0] mon_value;
    logic [7:0]            mon_consumed;

    assign mon_value    = m_axis_tdata[VALUE_BITS-1:0];
    assign mon_consumed = m_axis_tdata[VALUE_BITS+7:VALUE_BITS];

    `AIS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `AIS_ASSERT_RST(a_rst_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `AIS_ASSERT(a_rise_after_accept, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    `AIS_ASSERT(a_not_found_code, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> (mon_value == '1) || (mon_value == VMIN))
    `AIS_ASSERT(a_found_counted, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> mon_consumed != 8'd0)

endmodule

bind ascii_integer_scanner_core ais_checker #(
    .VALUE_BITS (VALUE_BITS),
    .OUT_W      (OUT_W)
) u_ais_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
